/* design/tfsc_pkg.sv */
// Shared types, constants and tables for the target follow speed controller.
// Used by tfsc_cordic and target_follow_speed_controller_core; no dependencies.
`default_nettype none

package tfsc_pkg;

    // Default parameter values.
    localparam int TIMEOUT_TICKS_DEF = 10;
    localparam int CORDIC_STEPS_DEF  = 16;

    // Datapath widths of the vectoring unit and the shared multiplier.
    localparam int XW     = 27;   // x/y in Q.8 scaled by 256, with CORDIC growth
    localparam int ZW     = 28;   // angle accumulator in Q.24 radians
    localparam int MUL_AW = 28;
    localparam int MUL_BW = 31;
    localparam int PROD_W = MUL_AW + MUL_BW;

    localparam logic signed [ZW-1:0]     HALF_PI_Q24  = 28'sd26353589;
    localparam logic signed [MUL_BW-1:0] INV_GAIN_Q30 = 31'sd652032874;
    localparam logic signed [16:0]       BEARING_MAX  = 17'sd25736;
    localparam logic [7:0]               AGE_MAX      = 8'd255;

    // Operating modes of the follower.
    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_TRACKING  = 2'd1,
        MODE_OCCLUDED  = 2'd2,
        MODE_CATCHUP   = 2'd3
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [3:0] {
        CFG_DISTANCE_UPPER       = 4'd0,
        CFG_DISTANCE_GOAL        = 4'd1,
        CFG_CRUISE_SPEED         = 4'd2,
        CFG_GAIN_DISTANCE        = 4'd3,
        CFG_GAIN_BEARING         = 4'd4,
        CFG_SPEED_LIMIT_TRACKING = 4'd5,
        CFG_SPEED_LIMIT_CATCHUP  = 4'd6,
        CFG_TURN_LIMIT           = 4'd7
    } cfg_index_t;

    // Sequencer states of the core.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MUL_DIST,
        ST_POST,
        ST_MUL_VX,
        ST_MUL_WZ,
        ST_FINISH
    } seq_state_t;

    // Status of the vectoring unit.
    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    // Arctangent of 2^-i in Q.24 radians.
    function automatic logic [23:0] atan_q24(input logic [4:0] idx);
        logic [23:0] a;
        case (idx)
            5'd0:    a = 24'd13176795;
            5'd1:    a = 24'd7778716;
            5'd2:    a = 24'd4110060;
            5'd3:    a = 24'd2086331;
            5'd4:    a = 24'd1047214;
            5'd5:    a = 24'd524117;
            5'd6:    a = 24'd262123;
            5'd7:    a = 24'd131069;
            5'd8:    a = 24'd65536;
            5'd9:    a = 24'd32768;
            5'd10:   a = 24'd16384;
            5'd11:   a = 24'd8192;
            5'd12:   a = 24'd4096;
            5'd13:   a = 24'd2048;
            5'd14:   a = 24'd1024;
            5'd15:   a = 24'd512;
            5'd16:   a = 24'd256;
            5'd17:   a = 24'd128;
            5'd18:   a = 24'd64;
            5'd19:   a = 24'd32;
            5'd20:   a = 24'd16;
            5'd21:   a = 24'd8;
            5'd22:   a = 24'd4;
            5'd23:   a = 24'd2;
            default: a = 24'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

/* design/tfsc_cordic.sv */
// Iterative CORDIC vectoring unit: one shift/add rotation per cycle.
// Depends on tfsc_pkg for widths, the quarter-turn constant and the arctangent table.
`default_nettype none

module tfsc_cordic #(
    parameter int CORDIC_STEPS = tfsc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [15:0]               x_in,
    input  logic signed [15:0]               y_in,
    output logic signed [tfsc_pkg::XW-1:0]   x_out,
    output logic signed [tfsc_pkg::ZW-1:0]   z_out,
    output tfsc_pkg::cordic_stat_t           stat
);

    localparam int XW = tfsc_pkg::XW;
    localparam int ZW = tfsc_pkg::ZW;
    localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [SW-1:0] LAST_STEP = SW'(CORDIC_STEPS - 1);

    logic                 busy_reg, busy_next;
    logic [SW-1:0]        step_reg, step_next;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;

    logic signed [XW-1:0] xs, ys, x_init, y_init;
    logic signed [ZW-1:0] z_init;
    logic signed [XW-1:0] dx, dy, x_iter, y_iter;
    logic signed [ZW-1:0] ang, z_iter;

    // Scale the Q8.8 position by 256 and fold the left half plane by a quarter turn.
    always_comb begin
        xs = {{(XW - 24){x_in[15]}}, x_in, 8'd0};
        ys = {{(XW - 24){y_in[15]}}, y_in, 8'd0};
        if (xs < 0) begin
            if (ys >= 0) begin
                x_init = ys;
                y_init = -xs;
                z_init = tfsc_pkg::HALF_PI_Q24;
            end else begin
                x_init = -ys;
                y_init = xs;
                z_init = -tfsc_pkg::HALF_PI_Q24;
            end
        end else begin
            x_init = xs;
            y_init = ys;
            z_init = '0;
        end
    end

    // One micro-rotation toward the x axis.
    always_comb begin
        dx  = y_reg >>> step_reg;
        dy  = x_reg >>> step_reg;
        ang = $signed({{(ZW - 24){1'b0}}, tfsc_pkg::atan_q24(5'(step_reg))});
        if (y_reg > 0) begin
            x_iter = x_reg + dx;
            y_iter = y_reg - dy;
            z_iter = z_reg + ang;
        end else begin
            x_iter = x_reg - dx;
            y_iter = y_reg + dy;
            z_iter = z_reg - ang;
        end
    end

    // Step counter control.
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (busy_reg) begin
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                step_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Vector registers carry no reset; they are loaded at start.
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= x_init;
            y_reg <= y_init;
            z_reg <= z_init;
        end else if (busy_reg) begin
            x_reg <= x_iter;
            y_reg <= y_iter;
            z_reg <= z_iter;
        end
    end

    assign x_out     = x_reg;
    assign z_out     = z_reg;
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (step_reg == LAST_STEP);

    // The step count never runs past the last rotation.
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg <= LAST_STEP)
        else $error("cordic step counter out of range");

    // The unit goes idle right after its last rotation.
    a_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.done && !start) |=> !busy_reg)
        else $error("cordic still busy after its last step");

    // Between start and the last rotation the step advances by one each cycle.
    a_step_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !stat.done && !start) |=> busy_reg && step_reg == $past(step_reg) + 1'b1)
        else $error("cordic step did not advance");

endmodule

`default_nettype wire

/* design/target_follow_speed_controller_core.sv */
// Top level of the target follow speed controller: channels, config registers,
// sequencer and shared multiplier. Depends on tfsc_pkg and tfsc_cordic.
//
// Usage: the input channel (s_valid/s_ready) carries two kinds of item. A pose
// item (s_command = 1) stores the target position and restarts the age counter
// and gives no result. A tick item (s_command = 0) ages the counter, runs a
// vectoring pass over the stored position, steps the mode machine and gives
// exactly one result item on the m_ channel.
// s_ready is low from the acceptance of a tick until the sequencer is idle
// again, so no new item is taken while a tick runs. A tick is a CORDIC pass,
// which does one rotation per cycle, followed by three passes through a single
// shared multiplier for range scaling, speed and turn rate.
// The result sits in an output register; a new item is accepted while it waits.
// If the receiver stalls, a finished tick holds in its last step until the
// previous result is taken. Configuration (cfg_valid/cfg_ready, always ready)
// must be written by the user only while the block is idle; the block itself
// does not enforce this. Writes to indexes beyond the list are ignored.
// Synchronous active-low reset returns mode to idle, clears the stored pose,
// age and seen flag, and restores register defaults.
`default_nettype none

module target_follow_speed_controller_core #(
    parameter int TIMEOUT_TICKS = tfsc_pkg::TIMEOUT_TICKS_DEF,
    parameter int CORDIC_STEPS  = tfsc_pkg::CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic signed [15:0] s_target_x,
    input  logic signed [15:0] s_target_y,
    // Result items
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_mode,
    output logic               m_fresh,
    output logic [15:0]        m_distance,
    output logic signed [15:0] m_bearing,
    output logic [11:0]        m_forward_speed,
    output logic signed [15:0] m_turn_rate,
    // Configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int XW     = tfsc_pkg::XW;
    localparam int ZW     = tfsc_pkg::ZW;
    localparam int MUL_AW = tfsc_pkg::MUL_AW;
    localparam int MUL_BW = tfsc_pkg::MUL_BW;
    localparam int PROD_W = tfsc_pkg::PROD_W;
    localparam logic [7:0] TIMEOUT = 8'(TIMEOUT_TICKS);
    localparam logic signed [PROD_W-1:0] DIST_HALF = PROD_W'(64'd1 << 37);
    localparam logic signed [PROD_W-1:0] VX_HALF   = PROD_W'(128);
    localparam logic signed [PROD_W-1:0] WZ_HALF   = PROD_W'(256);
    localparam logic signed [ZW-1:0]     BEAR_HALF = ZW'(1024);

    // Configuration registers
    logic [14:0] distance_upper_reg, distance_goal_reg, turn_limit_reg;
    logic [11:0] cruise_speed_reg, gain_distance_reg, gain_bearing_reg;
    logic [11:0] speed_limit_tracking_reg, speed_limit_catchup_reg;

    // Block state
    tfsc_pkg::seq_state_t state_reg, state_next;
    tfsc_pkg::mode_t      mode_reg, mode_next;
    logic signed [15:0]   stored_x_reg, stored_y_reg;
    logic                 seen_reg;
    logic [7:0]           age_reg, age_next;
    logic                 fresh_reg, fresh_next;
    logic                 zero_reg;

    // Working registers
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [15:0]              dist_reg, dist_next;
    logic signed [16:0]       bear_reg, bear_next;
    logic [11:0]              vx_reg, vx_next;

    // Output registers
    logic               m_valid_reg;
    tfsc_pkg::mode_t    m_mode_reg;
    logic               m_fresh_reg;
    logic [15:0]        m_distance_reg;
    logic signed [15:0] m_bearing_reg;
    logic [11:0]        m_forward_speed_reg;
    logic signed [15:0] m_turn_rate_reg;

    // Sequencer outputs
    logic tick_start, pose_take, mul_en, out_load;

    // Vectoring unit
    logic signed [XW-1:0]   cx_out;
    logic signed [ZW-1:0]   cz_out;
    tfsc_pkg::cordic_stat_t cstat;

    tfsc_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (tick_start),
        .x_in    (stored_x_reg),
        .y_in    (stored_y_reg),
        .x_out   (cx_out),
        .z_out   (cz_out),
        .stat    (cstat)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tfsc_pkg::ST_IDLE: begin
                if (s_valid && !s_command) begin
                    state_next = tfsc_pkg::ST_CORDIC;
                end
            end
            tfsc_pkg::ST_CORDIC: begin
                if (cstat.done) begin
                    state_next = tfsc_pkg::ST_MUL_DIST;
                end
            end
            tfsc_pkg::ST_MUL_DIST: state_next = tfsc_pkg::ST_POST;
            tfsc_pkg::ST_POST:     state_next = tfsc_pkg::ST_MUL_VX;
            tfsc_pkg::ST_MUL_VX:   state_next = tfsc_pkg::ST_MUL_WZ;
            tfsc_pkg::ST_MUL_WZ:   state_next = tfsc_pkg::ST_FINISH;
            tfsc_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = tfsc_pkg::ST_IDLE;
                end
            end
            default: state_next = tfsc_pkg::ST_IDLE;
        endcase
    end

    // Output logic of the sequencer.
    always_comb begin
        s_ready    = 1'b0;
        tick_start = 1'b0;
        pose_take  = 1'b0;
        mul_en     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            tfsc_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                tick_start = s_valid && !s_command;
                pose_take  = s_valid && s_command;
            end
            tfsc_pkg::ST_MUL_DIST,
            tfsc_pkg::ST_MUL_VX,
            tfsc_pkg::ST_MUL_WZ: mul_en = 1'b1;
            tfsc_pkg::ST_FINISH: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tfsc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration writes; data is truncated to each register's width.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            distance_upper_reg       <= 15'd640;
            distance_goal_reg        <= 15'd512;
            cruise_speed_reg         <= 12'd256;
            gain_distance_reg        <= 12'd128;
            gain_bearing_reg         <= 12'd256;
            speed_limit_tracking_reg <= 12'd384;
            speed_limit_catchup_reg  <= 12'd640;
            turn_limit_reg           <= 15'd4096;
        end else if (cfg_valid) begin
            case (tfsc_pkg::cfg_index_t'(cfg_index))
                tfsc_pkg::CFG_DISTANCE_UPPER:       distance_upper_reg       <= cfg_data[14:0];
                tfsc_pkg::CFG_DISTANCE_GOAL:        distance_goal_reg        <= cfg_data[14:0];
                tfsc_pkg::CFG_CRUISE_SPEED:         cruise_speed_reg         <= cfg_data[11:0];
                tfsc_pkg::CFG_GAIN_DISTANCE:        gain_distance_reg        <= cfg_data[11:0];
                tfsc_pkg::CFG_GAIN_BEARING:         gain_bearing_reg         <= cfg_data[11:0];
                tfsc_pkg::CFG_SPEED_LIMIT_TRACKING: speed_limit_tracking_reg <= cfg_data[11:0];
                tfsc_pkg::CFG_SPEED_LIMIT_CATCHUP:  speed_limit_catchup_reg  <= cfg_data[11:0];
                tfsc_pkg::CFG_TURN_LIMIT:           turn_limit_reg           <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Age the observation and judge freshness on a tick.
    always_comb begin
        age_next   = (age_reg == tfsc_pkg::AGE_MAX) ? age_reg : age_reg + 8'd1;
        fresh_next = seen_reg && (age_next <= TIMEOUT);
    end

    // Shared multiplier: range scaling, then speed error, then bearing.
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [16:0]       dist_err;

    always_comb begin
        dist_err = $signed({1'b0, dist_reg}) - $signed({2'b00, distance_goal_reg});
        case (state_reg)
            tfsc_pkg::ST_MUL_DIST: begin
                mul_a = MUL_AW'(cx_out);
                mul_b = tfsc_pkg::INV_GAIN_Q30;
            end
            tfsc_pkg::ST_MUL_VX: begin
                mul_a = MUL_AW'(dist_err);
                mul_b = $signed({{(MUL_BW - 12){1'b0}}, gain_distance_reg});
            end
            tfsc_pkg::ST_MUL_WZ: begin
                mul_a = MUL_AW'(bear_reg);
                mul_b = $signed({{(MUL_BW - 12){1'b0}}, gain_bearing_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Range and bearing rounding with saturation, and the mode step.
    logic signed [PROD_W-1:0] dist_sum;
    logic signed [20:0]       dist_q;
    logic signed [ZW-1:0]     bear_sum;
    logic signed [16:0]       bear_q;

    always_comb begin
        dist_sum = prod_reg + DIST_HALF;
        dist_q   = dist_sum[PROD_W-1:38];
        bear_sum = cz_out + BEAR_HALF;
        bear_q   = bear_sum[27:11];
        if (zero_reg || dist_q < 0) begin
            dist_next = '0;
        end else if (dist_q > 21'sd65535) begin
            dist_next = 16'hFFFF;
        end else begin
            dist_next = dist_q[15:0];
        end
        if (zero_reg) begin
            bear_next = '0;
        end else if (bear_q > tfsc_pkg::BEARING_MAX) begin
            bear_next = tfsc_pkg::BEARING_MAX;
        end else if (bear_q < -tfsc_pkg::BEARING_MAX) begin
            bear_next = -tfsc_pkg::BEARING_MAX;
        end else begin
            bear_next = bear_q;
        end

        mode_next = mode_reg;
        case (mode_reg)
            tfsc_pkg::MODE_IDLE: begin
                if (fresh_reg) mode_next = tfsc_pkg::MODE_TRACKING;
            end
            tfsc_pkg::MODE_TRACKING: begin
                if (!fresh_reg) mode_next = tfsc_pkg::MODE_OCCLUDED;
            end
            tfsc_pkg::MODE_OCCLUDED: begin
                if (fresh_reg) mode_next = tfsc_pkg::MODE_CATCHUP;
            end
            tfsc_pkg::MODE_CATCHUP: begin
                if (!fresh_reg) begin
                    mode_next = tfsc_pkg::MODE_OCCLUDED;
                end else if (dist_next <= {1'b0, distance_upper_reg}) begin
                    mode_next = tfsc_pkg::MODE_TRACKING;
                end else begin
                    mode_next = tfsc_pkg::MODE_CATCHUP;
                end
            end
            default: mode_next = tfsc_pkg::MODE_IDLE;
        endcase
    end

    // Forward speed: cruise plus rounded error term, clamped between zero and the mode ceiling.
    logic signed [PROD_W-1:0] vx_rnd;
    logic signed [28:0]       vx_term;
    logic signed [29:0]       vx_sum;
    logic [11:0]              vx_ceiling;

    always_comb begin
        vx_rnd     = prod_reg + VX_HALF;
        vx_term    = vx_rnd[36:8];
        vx_sum     = $signed({18'd0, cruise_speed_reg}) + 30'(vx_term);
        vx_ceiling = (mode_reg == tfsc_pkg::MODE_CATCHUP) ? speed_limit_catchup_reg
                                                          : speed_limit_tracking_reg;
        if (vx_sum < 0) begin
            vx_next = '0;
        end else if (vx_sum > $signed({18'd0, vx_ceiling})) begin
            vx_next = vx_ceiling;
        end else begin
            vx_next = vx_sum[11:0];
        end
    end

    // Turn rate: rounded bearing term, clamped to the turn ceiling.
    logic signed [PROD_W-1:0] wz_rnd;
    logic signed [27:0]       wz_term, wz_lim, wz_val;

    always_comb begin
        wz_rnd  = prod_reg + WZ_HALF;
        wz_term = wz_rnd[36:9];
        wz_lim  = $signed({13'd0, turn_limit_reg});
        if (wz_term > wz_lim) begin
            wz_val = wz_lim;
        end else if (wz_term < -wz_lim) begin
            wz_val = -wz_lim;
        end else begin
            wz_val = wz_term;
        end
    end

    // Control state: mode, stored pose, seen flag, age, freshness and zero-position flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= tfsc_pkg::MODE_IDLE;
            stored_x_reg <= '0;
            stored_y_reg <= '0;
            seen_reg     <= 1'b0;
            age_reg      <= '0;
            fresh_reg    <= 1'b0;
            zero_reg     <= 1'b0;
        end else begin
            if (pose_take) begin
                stored_x_reg <= s_target_x;
                stored_y_reg <= s_target_y;
                seen_reg     <= 1'b1;
                age_reg      <= '0;
            end
            if (tick_start) begin
                age_reg   <= age_next;
                fresh_reg <= fresh_next;
                zero_reg  <= (stored_x_reg == 16'sd0) && (stored_y_reg == 16'sd0);
            end
            if (state_reg == tfsc_pkg::ST_POST) begin
                mode_reg <= mode_next;
            end
        end
    end

    // Working registers of the arithmetic passes.
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod_next;
        end
        if (state_reg == tfsc_pkg::ST_POST) begin
            dist_reg <= dist_next;
            bear_reg <= bear_next;
        end
        if (state_reg == tfsc_pkg::ST_MUL_WZ) begin
            vx_reg <= vx_next;
        end
    end

    // Result register; stopped modes report all motion fields as zero.
    logic moving;
    assign moving = (mode_reg == tfsc_pkg::MODE_TRACKING) ||
                    (mode_reg == tfsc_pkg::MODE_CATCHUP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_mode_reg          <= mode_reg;
            m_fresh_reg         <= fresh_reg;
            m_distance_reg      <= moving ? dist_reg : 16'd0;
            m_bearing_reg       <= moving ? bear_reg[15:0] : 16'sd0;
            m_forward_speed_reg <= moving ? vx_reg : 12'd0;
            m_turn_rate_reg     <= moving ? wz_val[15:0] : 16'sd0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_mode          = m_mode_reg;
    assign m_fresh         = m_fresh_reg;
    assign m_distance      = m_distance_reg;
    assign m_bearing       = m_bearing_reg;
    assign m_forward_speed = m_forward_speed_reg;
    assign m_turn_rate     = m_turn_rate_reg;

    // A fresh result always lands in a moving mode, a stale one in a stopped mode.
    a_fresh_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_fresh == ((m_mode == tfsc_pkg::MODE_TRACKING) ||
                                (m_mode == tfsc_pkg::MODE_CATCHUP)))
        else $error("freshness and mode disagree");

    // Stopped modes give a zero command.
    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((m_mode == tfsc_pkg::MODE_IDLE) || (m_mode == tfsc_pkg::MODE_OCCLUDED)))
        |-> (m_distance == 16'd0 && m_bearing == 16'sd0 &&
             m_forward_speed == 12'd0 && m_turn_rate == 16'sd0))
        else $error("stopped mode with nonzero command");

    // An accepted tick starts the vectoring unit in the next cycle.
    a_tick_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_command) |=> (state_reg == tfsc_pkg::ST_CORDIC && cstat.busy))
        else $error("tick did not start the vectoring pass");

    // The vectoring unit only runs while the sequencer waits on it.
    a_cordic_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        cstat.busy |-> (state_reg == tfsc_pkg::ST_CORDIC && !s_ready))
        else $error("vectoring unit busy outside its step");

endmodule

`default_nettype wire
